// ===== sv/bmscan_pkg.sv =====
// Shared types and constants for the bitmap next-set-bit scanner.
`default_nettype none

package bmscan_pkg;

    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = 64;

    localparam int OFS_W  = $clog2(WORD_BITS);
    localparam int WIDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int POS_W  = 13;
    localparam int BIDX_W = 12;

    localparam logic [POS_W-1:0] TOTAL_BITS = POS_W'(MAP_WORDS * WORD_BITS);

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_RESTART = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  word_index;
        logic [63:0] word_data;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [BIDX_W-1:0] bit_index;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COUNT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic write_word;
        logic restart;
        logic fetch;
        logic scan_step;
        logic capture_hit;
        logic count;
        logic set_miss;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic start_past_limit;
        logic hit;
        logic last_word;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/bitmap_next_set_bit_scanner.sv =====
// Top level of the bitmap next-set-bit scanner.
// Write and restart words are acted on when they are accepted. An advance word
// reads the bitmap words from the scan position onward, one word per cycle
// through the one read port of the word store, examining 1 to MAP_WORDS words;
// on a set bit it counts the trailing zeros of that word, else it ends in a
// miss, and it goes straight to a miss when the position is already at or past
// the limit. A new input word is taken only once the previous advance has put
// its result in the output register; that result may wait there while the next
// word is accepted. cfg_data sets bit_count and is always ready.
`default_nettype none

module bitmap_next_set_bit_scanner
    import bmscan_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    bmscan_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready_ok (1'b1),
        .in_op       (in_item.op),
        .status      (status),
        .in_ready    (in_ready),
        .cmd         (cmd)
    );

    bmscan_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== sv/bmscan_ctrl.sv =====
// Control state machine for the bitmap scanner.
`default_nettype none

module bmscan_ctrl
    import bmscan_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_ready_ok,
    input  wire logic [1:0] in_op,
    input  wire status_t status,
    output logic         in_ready,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_op == OP_ADVANCE)
                begin
                    state_next = status.start_past_limit ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = ST_COUNT;
                end
                else if (status.last_word)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_COUNT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = in_ready_ok;
                if (accept)
                begin
                    case (in_op)
                        OP_WRITE:   cmd.write_word = 1'b1;
                        OP_RESTART: cmd.restart    = 1'b1;
                        OP_ADVANCE:
                        begin
                            cmd.fetch    = !status.start_past_limit;
                            cmd.set_miss = status.start_past_limit;
                        end
                        default:    cmd = '0;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    cmd.capture_hit = 1'b1;
                end
                else if (status.last_word)
                begin
                    cmd.set_miss = 1'b1;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_COUNT:
            begin
                cmd.count = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bmscan_dp.sv =====
// Datapath of the bitmap scanner: word store, position, masking, bit count, result register.
`default_nettype none

module bmscan_dp
    import bmscan_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [12:0] cfg_data,
    input  wire in_item_t    in_item,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item
);

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    // bitmap word store with per-word valid bits (unwritten words read as zero)
    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] word_valid_reg;

    logic [POS_W-1:0]     bit_count_reg;
    logic [POS_W-1:0]     scan_start_reg;
    logic [WIDX_W-1:0]    cur_wi_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_ok_reg;
    logic [WORD_BITS-1:0] hit_word_reg;
    logic [WIDX_W-1:0]    hit_wi_reg;
    logic                 res_found_reg;
    logic [POS_W-1:0]     res_pos_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    logic [POS_W-1:0]     limit;
    logic [WIDX_W-1:0]    start_wi;
    logic [OFS_W-1:0]     start_ofs;
    logic [WIDX_W-1:0]    last_wi;
    logic [OFS_W-1:0]     limit_ofs;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] word_val;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] masked;
    logic [OFS_W-1:0]     tz;
    logic                 wr_in_range;

    // trailing zero count by halving; the word is known to be nonzero
    function automatic logic [OFS_W-1:0] ctz(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [OFS_W-1:0]     n;
        v = w;
        n = '0;
        for (int s = OFS_W - 1; s >= 0; s--)
        begin
            if ((v & ~(ONES << (1 << s))) == '0)
            begin
                n[s] = 1'b1;
                v    = v >> (1 << s);
            end
        end
        return n;
    endfunction

    assign limit     = (bit_count_reg < TOTAL_BITS) ? bit_count_reg : TOTAL_BITS;
    assign start_wi  = WIDX_W'(scan_start_reg >> OFS_W);
    assign start_ofs = scan_start_reg[OFS_W-1:0];
    assign last_wi   = WIDX_W'((limit - POS_W'(1)) >> OFS_W);
    assign limit_ofs = limit[OFS_W-1:0];
    assign rd_addr   = cmd.fetch ? start_wi : cur_wi_reg + WIDX_W'(1);
    assign word_val  = rd_ok_reg ? rd_data_reg : '0;

    assign lo_mask = (cur_wi_reg == start_wi) ? (ONES << start_ofs) : ONES;
    assign hi_mask = (cur_wi_reg == last_wi && limit_ofs != '0) ? ~(ONES << limit_ofs) : ONES;
    assign masked  = word_val & lo_mask & hi_mask;
    assign tz      = ctz(hit_word_reg);

    assign wr_in_range = 32'(in_item.word_index) < 32'(MAP_WORDS);

    assign status.start_past_limit = scan_start_reg >= limit;
    assign status.hit              = |masked;
    assign status.last_word        = cur_wi_reg == last_wi;
    assign status.out_free         = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_word && wr_in_range)
        begin
            mem[WIDX_W'(in_item.word_index)] <= in_item.word_data[WORD_BITS-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_ok_reg      <= 1'b0;
            bit_count_reg  <= '0;
            scan_start_reg <= '0;
            cur_wi_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write_word && wr_in_range)
            begin
                word_valid_reg[WIDX_W'(in_item.word_index)] <= 1'b1;
            end
            rd_ok_reg <= word_valid_reg[rd_addr];
            if (cfg_valid)
            begin
                bit_count_reg <= cfg_data;
            end
            if (cmd.fetch)
            begin
                cur_wi_reg <= start_wi;
            end
            else if (cmd.scan_step)
            begin
                cur_wi_reg <= cur_wi_reg + WIDX_W'(1);
            end
            if (cmd.restart)
            begin
                scan_start_reg <= '0;
            end
            else if (cmd.load_out && res_found_reg)
            begin
                scan_start_reg <= res_pos_reg + POS_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_hit)
        begin
            hit_word_reg <= masked;
            hit_wi_reg   <= cur_wi_reg;
        end
        if (cmd.count)
        begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= (POS_W'(hit_wi_reg) << OFS_W) | POS_W'(tz);
        end
        else if (cmd.set_miss)
        begin
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        if (cmd.load_out)
        begin
            out_item_reg.found     <= res_found_reg;
            out_item_reg.bit_index <= res_pos_reg[BIDX_W-1:0];
        end
    end

endmodule

`default_nettype wire
